// ===== design/kslpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kslpd_pkg
// Shared constants and types for the short/long key press detector.
// ----------------------------------------------------------------------------
package kslpd_pkg;

    localparam int NUM_KEYS   = 4;
    localparam int LEVEL_BITS = 4;
    localparam int HOLD_W     = 16;
    localparam int KIND_W     = 2;
    localparam int IDX_W      = 2;

    localparam logic [HOLD_W-1:0] HOLD_MAX      = 16'hFFFF;
    localparam logic [HOLD_W-1:0] THRESH_RESET  = 16'd50;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind EV_NONE  = 2'd0;
    localparam t_kind EV_SHORT = 2'd1;
    localparam t_kind EV_LONG  = 2'd2;

    typedef t_kind [NUM_KEYS-1:0] t_kind_vec;

    // handshake toward the merge stage
    typedef struct packed {
        logic accept;
        logic out_stall;
    } t_merge_ctl;

endpackage
`default_nettype wire

// ===== design/kslpd_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kslpd_lane
// One key: saturating hold counter, long-fired flag, event decode per tick.
// ----------------------------------------------------------------------------
module kslpd_lane
    import kslpd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic              i_pressed,
    input  wire logic [HOLD_W-1:0] i_threshold,
    output t_kind                  o_kind
);

    logic [HOLD_W-1:0] r_hold_count;
    logic [HOLD_W-1:0] n_hold_count;
    logic              r_long_done;
    logic              n_long_done;
    logic [HOLD_W-1:0] hold_inc;

    assign hold_inc = (r_hold_count == HOLD_MAX) ? r_hold_count
                                                 : r_hold_count + 1'b1;

    always_comb begin
        n_hold_count = r_hold_count;
        n_long_done  = r_long_done;
        o_kind       = EV_NONE;
        if (i_pressed) begin
            n_hold_count = hold_inc;
            if (!r_long_done && hold_inc >= i_threshold) begin
                n_long_done = 1'b1;
                o_kind      = EV_LONG;
            end
        end else if (r_hold_count != '0) begin
            n_hold_count = '0;
            n_long_done  = 1'b0;
            if (!r_long_done) begin
                o_kind = EV_SHORT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_count <= '0;
            r_long_done  <= 1'b0;
        end else if (i_accept) begin
            r_hold_count <= n_hold_count;
            r_long_done  <= n_long_done;
        end
    end

endmodule
`default_nettype wire

// ===== design/kslpd_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kslpd_merge
// Picks the lowest-index key with an event and holds the result word.
// ----------------------------------------------------------------------------
module kslpd_merge
    import kslpd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_merge_ctl       i_ctl,
    input  wire t_kind_vec        i_kinds,
    output logic                  o_valid,
    output t_kind                 o_event_kind,
    output logic [IDX_W-1:0]      o_key_index
);

    t_kind             sel_kind;
    logic [IDX_W-1:0]  sel_idx;
    logic              r_valid;
    t_kind             r_kind;
    logic [IDX_W-1:0]  r_idx;

    // walk from the top so the lowest key wins
    always_comb begin
        sel_kind = EV_NONE;
        sel_idx  = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--) begin
            if (i_kinds[k] != EV_NONE) begin
                sel_kind = i_kinds[k];
                sel_idx  = IDX_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.accept) begin
            r_valid <= 1'b1;
        end else if (!i_ctl.out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_kind <= sel_kind;
            r_idx  <= sel_idx;
        end
    end

    assign o_valid      = r_valid;
    assign o_event_kind = r_kind;
    assign o_key_index  = r_idx;

endmodule
`default_nettype wire

// ===== design/key_short_long_press_detector_unit.sv =====
`default_nettype none
// A tick word's result word is registered and appears in the cycle after it is accepted.
// Throughput: one tick word per cycle; the single output register drains and
// refills in the same cycle, so input stall only rises while the output stalls.
// Reset (synchronous, active low) clears all hold counters and long flags,
// empties the output register and sets long_threshold to 50.
// ----------------------------------------------------------------------------
// key_short_long_press_detector_unit
// Per-key press lanes side by side, merged into one event word per tick.
// ----------------------------------------------------------------------------
module key_short_long_press_detector_unit
    import kslpd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [HOLD_W-1:0]     i_cfg_wdata,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [LEVEL_BITS-1:0] i_key_levels,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [KIND_W-1:0]          o_event_kind,
    output logic [IDX_W-1:0]           o_key_index
);

    logic [HOLD_W-1:0] r_long_threshold;
    logic              accept;
    logic [NUM_KEYS-1:0] pressed;
    t_kind_vec         kinds;
    t_merge_ctl        ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_threshold <= THRESH_RESET;
        end else if (i_cfg_we) begin
            r_long_threshold <= i_cfg_wdata;
        end
    end

    assign o_stall = o_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign ctl.accept    = accept;
    assign ctl.out_stall = i_stall;

    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
        // keys past the level field read as released
        if (g < LEVEL_BITS) begin : g_pin
            assign pressed[g] = ~i_key_levels[g];
        end else begin : g_none
            assign pressed[g] = 1'b0;
        end

        kslpd_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_accept    (accept),
            .i_pressed   (pressed[g]),
            .i_threshold (r_long_threshold),
            .o_kind      (kinds[g])
        );
    end

    kslpd_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_kinds      (kinds),
        .o_valid      (o_valid),
        .o_event_kind (o_event_kind),
        .o_key_index  (o_key_index)
    );

endmodule
`default_nettype wire
